FILE: hdl/ura_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic range averager package
// Shared constants, the phase encoding, the per-item result record and the
// reciprocal constants for turning the echo width sum into centimetres.
// ----------------------------------------------------------------------------
`default_nettype none

package ura_pkg;

	// Number of measurements that are averaged into one distance.
	localparam int SAMPLES = 5;

	localparam int CFG_W    = 16;   // width of the timing registers
	localparam int CFG_IDX_W = 1;   // register index width
	localparam int TIMER_W  = 16;
	localparam int WIDTH_W  = 16;   // echo width counter
	localparam int SUM_W    = 20;   // echo width accumulator
	localparam int IDX_W    = 4;    // sample counter
	localparam int DIST_W   = 15;   // unsigned Q11.4 distance
	localparam int FRAC_W   = 4;

	localparam logic [CFG_W-1:0] TRIGGER_RESET = 16'd20000;
	localparam logic [CFG_W-1:0] SETTLE_RESET  = 16'd50000;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = 1'b1;

	// Sample counter limit, one bit wider so that it can hold SAMPLES itself.
	localparam logic [IDX_W:0] IDX_LIMIT = (IDX_W+1)'(SAMPLES);

	// Distance = floor(16 * sum / (58 * SAMPLES)). The divide is done as a
	// multiply by a rounded-up reciprocal; with the shift chosen as the
	// dividend width plus clog2 of the divisor the result is exact for every
	// dividend below 2**24.
	localparam int CM_DIVISOR = 58;
	localparam int DIVISOR    = CM_DIVISOR * SAMPLES;
	localparam int DIVIDEND_W = SUM_W + FRAC_W;
	localparam int DIV_SHIFT  = DIVIDEND_W + $clog2(DIVISOR);
	localparam int RECIP_W    = DIVIDEND_W + 2;
	localparam int PROD_W     = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
		((64'd1 << DIV_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

	typedef enum logic [4:0] {
		PH_IDLE   = 5'b00001,
		PH_TRIG   = 5'b00010,
		PH_WAIT   = 5'b00100,
		PH_MEAS   = 5'b01000,
		PH_SETTLE = 5'b10000
	} phase_t;

	// Result of one tick before the distance scaling.
	typedef struct packed {
		logic             trig;
		logic             busy;
		logic             valid;
		logic [SUM_W-1:0] sum;   // final width sum, zero unless valid
	} res_t;

endpackage

`default_nettype wire

FILE: hdl/ultrasonic_range_averager_unit.sv
// Pipeline: an accepted item is registered in stage one and then in stage two
// before its result shows on the outputs. Throughput: one item per cycle
// unless a full pipe waits on out_ready; the sequencer step and the reciprocal
// multiply each sit in their own stage, so nothing iterates.
// Reset: arst_n clears the phase, counters and stage valid bits at once and
// loads the trigger and settle registers with their default lengths.
// ----------------------------------------------------------------------------
// Ultrasonic range averager
// Per-microsecond sequencer that fires the trigger, times the echo of a number
// of measurements and reports their mean distance in centimetres.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_range_averager_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Input items: one per microsecond tick.
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          start_req,
	input  wire logic                          echo_level,
	// Result items: one per input item.
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               trigger_level,
	output logic                               busy_res,
	output logic                               distance_valid,
	output logic [ura_pkg::DIST_W-1:0]         distance_q4,
	// Configuration writes.
	input  wire logic                          cfg_we,
	input  wire logic [ura_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ura_pkg::CFG_W-1:0]     cfg_data
);

	// Stage one holds the sequencer result of an item, stage two the finished
	// result item with its scaled distance. Each stage loads when it is empty
	// or when the stage after it moves, so the pipe keeps one item per cycle
	// flowing and only stalls when both stages are full and the output waits.
	logic                         accept;
	logic                         en_s1, en_s2;
	logic                         v_s1, v_s2;
	ura_pkg::res_t                res_c, res_s1;
	logic [ura_pkg::DIST_W-1:0]   dist_c;
	logic                         trig_s2, busy_s2, valid_s2;
	logic [ura_pkg::DIST_W-1:0]   dist_s2;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign accept   = in_valid && in_ready;

	ura_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.start_req  (start_req),
		.echo_level (echo_level),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.res        (res_c)
	);

	// The sum is zero on ticks without a result, so the scaled distance is
	// zero there as well.
	ura_scale u_scale (
		.sum      (res_s1.sum),
		.range_q4 (dist_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= accept;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_c;
		end
		if (en_s2 && v_s1) begin
			trig_s2  <= res_s1.trig;
			busy_s2  <= res_s1.busy;
			valid_s2 <= res_s1.valid;
			dist_s2  <= dist_c;
		end
	end

	assign out_valid      = v_s2;
	assign trigger_level  = trig_s2;
	assign busy_res       = busy_s2;
	assign distance_valid = valid_s2;
	assign distance_q4    = dist_s2;

`ifndef SYNTHESIS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready && v_s1)
		else $error("input stalled while the pipe can move");

	a_dist_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !distance_valid |-> distance_q4 == '0)
		else $error("distance shown without a completed average");
`endif

endmodule

`default_nettype wire

FILE: hdl/ura_scale.sv
// ----------------------------------------------------------------------------
// Ultrasonic range averager distance scaling
// Converts the echo width sum into the averaged distance in Q11.4 centimetres
// with one multiply by a constant reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module ura_scale (
	input  wire logic [ura_pkg::SUM_W-1:0]  sum,
	output logic      [ura_pkg::DIST_W-1:0] range_q4
);

	logic [ura_pkg::PROD_W-1:0] prod;

	// The factor 16 of the fraction bits is folded into the shift.
	assign prod     = ura_pkg::PROD_W'(sum) * ura_pkg::PROD_W'(ura_pkg::RECIP);
	assign range_q4 = prod[ura_pkg::DIV_SHIFT-ura_pkg::FRAC_W +: ura_pkg::DIST_W];

endmodule

`default_nettype wire

FILE: hdl/ura_ctrl.sv
// ----------------------------------------------------------------------------
// Ultrasonic range averager sequencer
// Trigger, echo wait, echo width count and settle phases for each tick, the
// averaging counters and the two timing registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ura_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic                          start_req,
	input  wire logic                          echo_level,
	input  wire logic                          cfg_we,
	input  wire logic [ura_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ura_pkg::CFG_W-1:0]     cfg_data,
	output ura_pkg::res_t                      res
);

	ura_pkg::phase_t                 phase_q, phase_d;
	logic [ura_pkg::TIMER_W-1:0]     timer_q, timer_d, t_inc, tlen;
	logic [ura_pkg::WIDTH_W-1:0]     width_q, width_d;
	logic [ura_pkg::SUM_W-1:0]       sum_q, sum_d;
	logic [ura_pkg::IDX_W-1:0]       idx_q, idx_d;
	logic [ura_pkg::CFG_W-1:0]       trigger_us_q, settle_us_q;
	logic                            finish, last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_us_q <= ura_pkg::TRIGGER_RESET;
			settle_us_q  <= ura_pkg::SETTLE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ura_pkg::REG_TRIGGER: trigger_us_q <= cfg_data;
				ura_pkg::REG_SETTLE:  settle_us_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		width_d = width_q;
		sum_d   = sum_q;
		idx_d   = idx_q;
		finish  = 1'b0;
		res     = '0;
		// A zero trigger length still gives one trigger tick.
		tlen    = (trigger_us_q == '0) ? ura_pkg::TIMER_W'(1) : trigger_us_q;
		t_inc   = timer_q + ura_pkg::TIMER_W'(1);
		last    = ({1'b0, idx_q} + (ura_pkg::IDX_W+1)'(1)) >= ura_pkg::IDX_LIMIT;

		case (phase_q)
			ura_pkg::PH_TRIG: begin
				res.trig = 1'b1;
				res.busy = 1'b1;
				timer_d  = t_inc;
				if (t_inc >= tlen) begin
					phase_d = ura_pkg::PH_WAIT;
					timer_d = '0;
				end
			end
			ura_pkg::PH_WAIT: begin
				res.busy = 1'b1;
				if (echo_level) begin
					width_d = ura_pkg::WIDTH_W'(1);
					phase_d = ura_pkg::PH_MEAS;
				end
			end
			ura_pkg::PH_MEAS: begin
				res.busy = 1'b1;
				if (echo_level) begin
					if (width_q != '1) begin
						width_d = width_q + ura_pkg::WIDTH_W'(1);
					end
				end else begin
					sum_d   = sum_q + ura_pkg::SUM_W'(width_q);
					timer_d = '0;
					if (settle_us_q == '0) begin
						finish = 1'b1;
					end else begin
						phase_d = ura_pkg::PH_SETTLE;
					end
				end
			end
			ura_pkg::PH_SETTLE: begin
				res.busy = 1'b1;
				timer_d  = t_inc;
				if (t_inc >= settle_us_q) begin
					finish = 1'b1;
				end
			end
			default: begin
				phase_d = ura_pkg::PH_IDLE;
				if (start_req) begin
					phase_d = ura_pkg::PH_TRIG;
					timer_d = '0;
					width_d = '0;
					sum_d   = '0;
					idx_d   = '0;
				end
			end
		endcase

		if (finish) begin
			timer_d = '0;
			if (last) begin
				res.valid = 1'b1;
				res.sum   = sum_d;
				phase_d   = ura_pkg::PH_IDLE;
				idx_d     = '0;
			end else begin
				phase_d = ura_pkg::PH_TRIG;
				idx_d   = idx_q + ura_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ura_pkg::PH_IDLE;
			timer_q <= '0;
			width_q <= '0;
			sum_q   <= '0;
			idx_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			width_q <= width_d;
			sum_q   <= sum_d;
			idx_q   <= idx_d;
		end
	end

`ifndef SYNTHESIS
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.valid |=> phase_q == ura_pkg::PH_IDLE)
		else $error("sequence completed without returning to idle");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, idx_q} < ura_pkg::IDX_LIMIT)
		else $error("sample counter beyond the sample count");
`endif

endmodule

`default_nettype wire
